// ===== src/gasa_pkg.sv =====
// ----------------------------------------------------------------------------
// gasa_pkg
// Shared constants, codes and types of the glyph atlas shelf allocator.
// ----------------------------------------------------------------------------
package gasa_pkg;

  // Shelf table depth and largest atlas edge exponent
  localparam int unsigned MAX_SHELVES = 64;
  localparam int unsigned EDGE_BITS   = 14;

  localparam int unsigned PADDING     = 1;

  // Field and datapath widths
  localparam int unsigned COORD_W  = 14;            // rect sizes, placed x/y
  localparam int unsigned EDGE_W   = 15;            // edges, shelf coordinates
  localparam int unsigned SUM_W    = EDGE_W + 1;    // coordinate plus size
  localparam int unsigned PROD_W   = 2 * EDGE_W;
  localparam int unsigned OFFSET_W = 28;
  localparam int unsigned ATLAS_W  = 16;
  localparam int unsigned IDX_W    = $clog2(MAX_SHELVES);
  localparam int unsigned CNT_W    = $clog2(MAX_SHELVES + 1);

  localparam logic [SUM_W-1:0] EDGE_CAP = SUM_W'(1) << EDGE_BITS;

  // Stream packing
  localparam int unsigned IN_FIELDS_W  = 2 * COORD_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 2 * COORD_W + OFFSET_W + ATLAS_W + EDGE_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W  = 3;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_EDGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EDGE     = 1'd1;

  localparam logic [EDGE_W-1:0] INITIAL_EDGE_RST = 15'd512;
  localparam logic [EDGE_W-1:0] MAX_EDGE_RST     = 15'd4096;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EXTEND,
    ST_MUL,
    ST_FIN
  } gasa_state_t;

  // Effective configuration, from the register block to the controller
  typedef struct packed {
    logic              settled;
    logic [EDGE_W-1:0] eff_max;
    logic [EDGE_W-1:0] eff_init;
    logic [EDGE_W-1:0] top;
  } gasa_cfg_t;

  // Broadcast from the controller to every shelf cell
  typedef struct packed {
    logic [COORD_W-1:0] rect_w;
    logic [COORD_W-1:0] rect_h;
    logic [EDGE_W-1:0]  edge_len;
    logic [CNT_W-1:0]   count;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [EDGE_W-1:0]  wr_next_x;
    logic [EDGE_W-1:0]  wr_top_y;
    logic [EDGE_W-1:0]  wr_bottom;
  } gasa_ctl_t;

  // Response of one shelf cell; fields are zero unless hit or miss
  typedef struct packed {
    logic              hit;
    logic              miss;
    logic [EDGE_W-1:0] px;
    logic [EDGE_W-1:0] py;
    logic [EDGE_W-1:0] bottom;
  } gasa_rsp_t;

endpackage

// ===== src/gasa_cfg.sv =====
// ----------------------------------------------------------------------------
// gasa_cfg
// Configuration registers, effective edge limits and largest reachable edge.
// ----------------------------------------------------------------------------
module gasa_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [gasa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gasa_pkg::EDGE_W-1:0]        cfg_data,
  output gasa_pkg::gasa_cfg_t                cfg_o
);

  localparam int unsigned EW = gasa_pkg::EDGE_W;

  logic [EW-1:0]   init_edge_r;
  logic [EW-1:0]   max_edge_r;
  logic [EW-1:0]   eff_max_r;
  logic [EW-1:0]   eff_init_r;
  logic [EW-1:0]   top_r;
  logic [1:0]      settle_r;

  logic [gasa_pkg::SUM_W-1:0] max_ext;
  logic [EW-1:0]   eff_max_nxt;
  logic [EW-1:0]   eff_init_nxt;
  logic [EW-1:0]   top_nxt;
  logic [EW:0]     fits;
  logic [2*EW-1:0] shifted [EW];

  // Clamp max to [1, cap], then init to [1, max]
  assign max_ext = gasa_pkg::SUM_W'(max_edge_r);

  always_comb begin
    if (max_edge_r == '0) begin
      eff_max_nxt = EW'(1);
    end else if (max_ext > gasa_pkg::EDGE_CAP) begin
      eff_max_nxt = gasa_pkg::EDGE_CAP[EW-1:0];
    end else begin
      eff_max_nxt = max_edge_r;
    end
    if (init_edge_r == '0) begin
      eff_init_nxt = EW'(1);
    end else if (init_edge_r > eff_max_nxt) begin
      eff_init_nxt = eff_max_nxt;
    end else begin
      eff_init_nxt = init_edge_r;
    end
  end

  // Largest init << k not above max; fit flags form a prefix
  always_comb begin
    fits[EW] = 1'b0;
    for (int k = 0; k < EW; k++) begin
      shifted[k] = (2*EW)'(eff_init_r) << k;
      fits[k]    = shifted[k] <= (2*EW)'(eff_max_r);
    end
    top_nxt = '0;
    for (int k = 0; k < EW; k++) begin
      if (fits[k] && !fits[k+1]) begin
        top_nxt = top_nxt | shifted[k][EW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_edge_r <= gasa_pkg::INITIAL_EDGE_RST;
      max_edge_r  <= gasa_pkg::MAX_EDGE_RST;
      settle_r    <= 2'd2;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          gasa_pkg::REG_INITIAL_EDGE: init_edge_r <= cfg_data;
          gasa_pkg::REG_MAX_EDGE:     max_edge_r  <= cfg_data;
          default: ;
        endcase
        settle_r <= 2'd2;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    eff_max_r  <= eff_max_nxt;
    eff_init_r <= eff_init_nxt;
    top_r      <= top_nxt;
  end

  assign cfg_o.settled  = (settle_r == 2'd0);
  assign cfg_o.eff_max  = eff_max_r;
  assign cfg_o.eff_init = eff_init_r;
  assign cfg_o.top      = top_r;

endmodule

// ===== src/gasa_cell.sv =====
// ----------------------------------------------------------------------------
// gasa_cell
// One shelf of the atlas; tests the request when the scan token is here and
// hands the token to the next shelf when the rectangle does not fit there, unless it is the last shelf.
// ----------------------------------------------------------------------------
module gasa_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gasa_pkg::IDX_W-1:0]    cell_idx,
  input  gasa_pkg::gasa_ctl_t           ctl,
  input  logic                          tok_in,
  output logic                          tok_out,
  output gasa_pkg::gasa_rsp_t           rsp
);

  localparam int unsigned EW = gasa_pkg::EDGE_W;
  localparam int unsigned SW = gasa_pkg::SUM_W;
  localparam int unsigned CW = gasa_pkg::CNT_W;

  logic          tok_r;
  logic [EW-1:0] next_x_r;
  logic [EW-1:0] top_y_r;
  logic [EW-1:0] bottom_r;

  logic [SW-1:0] xe;
  logic [SW-1:0] ye;
  logic [SW-1:0] edge_ext;
  logic          last;
  logic          fits;
  logic          hit;
  logic          miss;

  assign xe       = SW'(next_x_r) + SW'(ctl.rect_w);
  assign ye       = SW'(top_y_r) + SW'(ctl.rect_h);
  assign edge_ext = SW'(ctl.edge_len);
  assign last     = (CW'(cell_idx) + CW'(1)) == ctl.count;

  // last shelf may grow downward; earlier ones must fit under their bottom
  assign fits = (xe < edge_ext) && (ye < edge_ext) && (last || (ye < SW'(bottom_r)));

  assign hit     = tok_r && fits;
  assign miss    = tok_r && !fits && last;
  assign tok_out = tok_r && !fits && !last;

  assign rsp.hit    = hit;
  assign rsp.miss   = miss;
  assign rsp.px     = hit  ? next_x_r : '0;
  assign rsp.py     = hit  ? top_y_r  : '0;
  assign rsp.bottom = miss ? bottom_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_idx == cell_idx)) begin
      next_x_r <= ctl.wr_next_x;
      top_y_r  <= ctl.wr_top_y;
      bottom_r <= ctl.wr_bottom;
    end else if (hit) begin
      next_x_r <= xe[EW-1:0] + EW'(gasa_pkg::PADDING);
      if (last && (ye > SW'(bottom_r))) begin
        bottom_r <= ye[EW-1:0];
      end
    end
  end

endmodule

// ===== src/glyph_atlas_shelf_allocator.sv =====
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_allocator
// First-fit shelf packer for square glyph atlases with grow and new-atlas
// fallback.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  in_      slave      in_tvalid / in_tready   tdata: rect_width, rect_height
//  out_     master     out_tvalid / out_tready tdata: x, y, offset, atlas, edge
//                                              tuser: grew, new_atlas, too_large
//  cfg_     slave      cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  One rectangle at a time. An accepted input beat is size-checked, then the
//  scan token walks the shelves of the open atlas. A pass that finds no fit
//  falls through to a new shelf, or doubles the edge or opens a new atlas
//  and scans again. The offset multiply and the final state come last.
//  The scan token moves one shelf cell per cycle. in_tready stays low after
//  reset and after every config write while the effective edge limits
//  settle. A result held by out_tready low does not block the next input
//  beat; that item waits in the final state.
//
module glyph_atlas_shelf_allocator (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [13:0] rect_width, [27:14] rect_height, [31:28] zero
  input  logic [gasa_pkg::IN_TDATA_W-1:0]      in_tdata,

  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [13:0] placed_x, [27:14] placed_y, [55:28] texel_offset,
  // [71:56] atlas_number, [86:72] edge_now, [87] zero
  output logic [gasa_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] grew, [1] new_atlas, [2] too_large
  output logic [gasa_pkg::OUT_TUSER_W-1:0]     out_tuser,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gasa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gasa_pkg::EDGE_W-1:0]          cfg_data
);

  localparam int unsigned NS = gasa_pkg::MAX_SHELVES;
  localparam int unsigned EW = gasa_pkg::EDGE_W;
  localparam int unsigned SW = gasa_pkg::SUM_W;
  localparam int unsigned CO = gasa_pkg::COORD_W;
  localparam int unsigned CW = gasa_pkg::CNT_W;
  localparam int unsigned IW = gasa_pkg::IDX_W;
  localparam int unsigned AW = gasa_pkg::ATLAS_W;
  localparam int unsigned OW = gasa_pkg::OFFSET_W;

  // --------------------------------------------------------------------------
  // Configuration block
  // --------------------------------------------------------------------------
  gasa_pkg::gasa_cfg_t cfg;

  assign cfg_ready = 1'b1;

  gasa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  gasa_pkg::gasa_state_t state_r, state_nxt;

  logic [CO-1:0]     w_r,      w_nxt;
  logic [CO-1:0]     h_r,      h_nxt;
  logic [EW-1:0]     px_r,     px_nxt;
  logic [EW-1:0]     py_r,     py_nxt;
  logic [gasa_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic              grew_r,   grew_nxt;
  logic              fresh_r,  fresh_nxt;
  logic              too_r,    too_nxt;
  logic [CW-1:0]     count_r,  count_nxt;   // shelves in the open atlas
  logic [EW-1:0]     edge_r,   edge_nxt;    // current atlas edge
  logic [AW-1:0]     atlas_r,  atlas_nxt;   // saturating atlas number
  logic              open_r,   open_nxt;
  logic [EW-1:0]     blast_r,  blast_nxt;   // bottom of the last shelf on a miss

  logic                            out_valid_r, out_valid_nxt;
  logic [gasa_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [gasa_pkg::OUT_TUSER_W-1:0] out_user_r, out_user_nxt;

  gasa_pkg::gasa_ctl_t ctl;
  logic                launch;     // token into shelf 0
  logic                open_req;   // start a fresh atlas this cycle

  // --------------------------------------------------------------------------
  // Shelf row
  // --------------------------------------------------------------------------
  gasa_pkg::gasa_rsp_t rsp_arr [NS];
  gasa_pkg::gasa_rsp_t rsp_any;
  logic [NS-1:0]       tok_link;
  logic [NS-1:0]       hit_vec;
  logic [NS-1:0]       miss_vec;

  for (genvar g = 0; g < NS; g++) begin : g_cell
    logic tok_in_g;
    if (g == 0) begin : g_head
      assign tok_in_g = launch;
    end else begin : g_body
      assign tok_in_g = tok_link[g-1];
    end

    gasa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IW'(g)),
      .ctl      (ctl),
      .tok_in   (tok_in_g),
      .tok_out  (tok_link[g]),
      .rsp      (rsp_arr[g])
    );

    assign hit_vec[g]  = rsp_arr[g].hit;
    assign miss_vec[g] = rsp_arr[g].miss;
  end

  // Only the cell holding the token drives nonzero fields
  always_comb begin
    rsp_any = '0;
    for (int i = 0; i < NS; i++) begin
      rsp_any = gasa_pkg::gasa_rsp_t'(rsp_any | rsp_arr[i]);
    end
  end

  // --------------------------------------------------------------------------
  // New-shelf and growth arithmetic
  // --------------------------------------------------------------------------
  logic [SW-1:0] new_y;
  logic [SW-1:0] new_bottom;
  logic          new_fits;
  logic          must_restart;
  logic [OW-1:0] offset;

  assign new_y      = SW'(blast_r) + SW'(gasa_pkg::PADDING);
  assign new_bottom = new_y + SW'(h_r);
  assign new_fits   = (count_r < CW'(NS)) && (new_bottom <= SW'(edge_r)) &&
                      (EW'(w_r) < edge_r);
  // doubling would pass the max edge
  assign must_restart = (SW'(edge_r) << 1) > SW'(cfg.eff_max);

  assign offset = prod_r[OW-1:0] + OW'(px_r);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  assign in_tready = (state_r == gasa_pkg::ST_IDLE) && cfg.settled;

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    prod_nxt      = prod_r;
    grew_nxt      = grew_r;
    fresh_nxt     = fresh_r;
    too_nxt       = too_r;
    count_nxt     = count_r;
    edge_nxt      = edge_r;
    atlas_nxt     = atlas_r;
    open_nxt      = open_r;
    blast_nxt     = blast_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    launch        = 1'b0;
    open_req      = 1'b0;

    ctl           = '0;
    ctl.rect_w    = w_r;
    ctl.rect_h    = h_r;
    ctl.edge_len  = edge_r;
    ctl.count     = count_r;

    case (state_r)
      gasa_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          w_nxt     = in_tdata[CO-1:0];
          h_nxt     = in_tdata[2*CO-1:CO];
          grew_nxt  = 1'b0;
          fresh_nxt = 1'b0;
          too_nxt   = 1'b0;
          state_nxt = gasa_pkg::ST_CHECK;
        end
      end

      gasa_pkg::ST_CHECK: begin
        if ((EW'(w_r) >= cfg.top) || (EW'(h_r) >= cfg.top)) begin
          // never fits; report state unchanged
          too_nxt   = 1'b1;
          px_nxt    = '0;
          py_nxt    = '0;
          state_nxt = gasa_pkg::ST_MUL;
        end else begin
          open_req  = !open_r;
          launch    = 1'b1;
          state_nxt = gasa_pkg::ST_SCAN;
        end
      end

      gasa_pkg::ST_SCAN: begin
        if (rsp_any.hit) begin
          px_nxt    = rsp_any.px;
          py_nxt    = rsp_any.py;
          state_nxt = gasa_pkg::ST_MUL;
        end else if (rsp_any.miss) begin
          blast_nxt = rsp_any.bottom;
          state_nxt = gasa_pkg::ST_EXTEND;
        end
      end

      gasa_pkg::ST_EXTEND: begin
        if (new_fits) begin
          ctl.wr_en     = 1'b1;
          ctl.wr_idx    = count_r[IW-1:0];
          ctl.wr_next_x = EW'(w_r) + EW'(gasa_pkg::PADDING);
          ctl.wr_top_y  = new_y[EW-1:0];
          ctl.wr_bottom = new_bottom[EW-1:0];
          count_nxt     = count_r + CW'(1);
          px_nxt        = '0;
          py_nxt        = new_y[EW-1:0];
          state_nxt     = gasa_pkg::ST_MUL;
        end else begin
          if (must_restart) begin
            open_req = 1'b1;
          end else begin
            edge_nxt = edge_r << 1;
            grew_nxt = 1'b1;
          end
          launch    = 1'b1;
          state_nxt = gasa_pkg::ST_SCAN;
        end
      end

      gasa_pkg::ST_MUL: begin
        prod_nxt  = gasa_pkg::PROD_W'(py_r) * gasa_pkg::PROD_W'(edge_r);
        state_nxt = gasa_pkg::ST_FIN;
      end

      gasa_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = gasa_pkg::OUT_TDATA_W'({edge_r, atlas_r, offset,
                                                  py_r[CO-1:0], px_r[CO-1:0]});
          out_user_nxt  = {too_r, fresh_r, grew_r};
          state_nxt     = gasa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = gasa_pkg::ST_IDLE;
      end
    endcase

    // fresh atlas: one empty shelf at the top, edge back to the initial size
    if (open_req) begin
      ctl.wr_en     = 1'b1;
      ctl.wr_idx    = '0;
      ctl.wr_next_x = '0;
      ctl.wr_top_y  = '0;
      ctl.wr_bottom = '0;
      count_nxt     = CW'(1);
      edge_nxt      = cfg.eff_init;
      open_nxt      = 1'b1;
      fresh_nxt     = 1'b1;
      if (open_r && (atlas_r != '1)) begin
        atlas_nxt = atlas_r + AW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gasa_pkg::ST_IDLE;
      count_r     <= '0;
      edge_r      <= '0;
      atlas_r     <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      edge_r      <= edge_nxt;
      atlas_r     <= atlas_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    prod_r     <= prod_nxt;
    grew_r     <= grew_nxt;
    fresh_r    <= fresh_nxt;
    too_r      <= too_nxt;
    blast_r    <= blast_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // at most one shelf answers per cycle
  a_single_answer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({hit_vec, miss_vec}))
    else $error("more than one shelf cell answered");

  // shelves answer only while the controller is scanning
  a_answer_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ((|hit_vec) || (|miss_vec)) |-> (state_r == gasa_pkg::ST_SCAN))
    else $error("shelf answer outside scan");

  // the token stops at the last shelf and never leaves the row
  a_token_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !tok_link[NS-1])
    else $error("scan token ran past the last shelf");

  // shelf count bounded, and zero until an atlas is open
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CW'(NS)) && (open_r || (count_r == '0)))
    else $error("shelf count out of range");

endmodule
